// ===== rtl/core/lod_cut_cluster_select_unit_defines.svh =====
// Assertion macros shared by the RTL of the cluster select unit.
`ifndef LOD_CUT_CLUSTER_SELECT_UNIT_DEFINES_SVH
`define LOD_CUT_CLUSTER_SELECT_UNIT_DEFINES_SVH

`ifndef NO_ASSERTIONS
// The consequent must hold in the same cycle as the antecedent.
`define LCCS_ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed: same-cycle implication");
// The consequent must hold in the cycle after the antecedent.
`define LCCS_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed: next-cycle implication");
`else
`define LCCS_ASSERT_SAME(label, clk, rst, ante, cons)
`define LCCS_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif

`endif

// ===== rtl/core/lccs_pkg.sv =====
`default_nettype none

package lccs_pkg;

   localparam int COORD_W  = 32;
   localparam int DIFF_W   = 32;
   localparam int SQ_W     = 2 * DIFF_W;
   localparam int SUM_W    = SQ_W + 2;
   localparam int ROOT_W   = DIFF_W + 1;
   localparam int REM_W    = SUM_W + 1;
   localparam int BUDGET_W = 16;
   localparam int INDEX_W  = 24;
   localparam int BUDGET_SHIFT = 8;

   // Difference, square, sum, one stage per root bit, then three compare stages.
   localparam int PROJ_LAT = ROOT_W + 6;

   localparam int CSR_ADDR_W = 5;
   localparam int CSR_DATA_W = 32;

   typedef enum logic [2:0] {
      REG_CAMERA_X     = 3'd0,
      REG_CAMERA_Y     = 3'd1,
      REG_CAMERA_Z     = 3'd2,
      REG_PIXEL_SCALE  = 3'd3,
      REG_ERROR_BUDGET = 3'd4
   } lccs_reg_type;

   typedef struct packed {
      logic signed [COORD_W-1:0] x;
      logic signed [COORD_W-1:0] y;
      logic signed [COORD_W-1:0] z;
   } lccs_cam_type;

   typedef struct packed {
      logic [COORD_W-1:0]  pixel_scale;
      logic [BUDGET_W-1:0] error_budget;
   } lccs_scale_type;

   typedef struct packed {
      logic [COORD_W-1:0]        err;
      logic signed [COORD_W-1:0] cx;
      logic signed [COORD_W-1:0] cy;
      logic signed [COORD_W-1:0] cz;
      logic [COORD_W-1:0]        radius;
   } lccs_sphere_type;

endpackage

`default_nettype wire

// ===== rtl/core/lod_cut_cluster_select_unit.sv =====
// Channel    Direction  Handshake              Payload
// req_       in         req_tvalid/req_tready  tdata: cluster record, tuser: has_parent
// rsp_       out        rsp_tvalid/rsp_tready  tdata: result_index, tuser: selected
// csr_       in         APB, pready always 1   five registers at byte address 4*i
//
// One request is taken per clock cycle unless the output stalls.
// The latency is set by the square root, which resolves one bit of the
// distance per pipeline stage, followed by the product and compare stages.
// Reset clears the valid bits and loads the register reset values.
// When a result waits at the output the whole pipeline holds and req_tready falls.
`default_nettype none
`include "lod_cut_cluster_select_unit_defines.svh"

module lod_cut_cluster_select_unit
   import lccs_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_tvalid,
   output logic                       req_tready,
   // cluster_index, own_error, own_center_x/y/z, own_radius, parent_error,
   // parent_center_x/y/z, parent_radius
   input  wire logic [343:0]          req_tdata,
   // has_parent
   input  wire logic [0:0]            req_tuser,
   output logic                       rsp_tvalid,
   input  wire logic                  rsp_tready,
   // result_index
   output logic [INDEX_W-1:0]         rsp_tdata,
   // selected
   output logic [0:0]                 rsp_tuser,
   input  wire logic                  csr_psel,
   input  wire logic                  csr_penable,
   input  wire logic                  csr_pwrite,
   input  wire logic [CSR_ADDR_W-1:0] csr_paddr,
   input  wire logic [CSR_DATA_W-1:0] csr_pwdata,
   output logic [CSR_DATA_W-1:0]      csr_prdata,
   output logic                       csr_pready
);

   lccs_cam_type    cam_ff;
   lccs_scale_type  scale_ff;
   lccs_sphere_type own_sph, par_sph;
   lccs_reg_type    reg_sel;
   logic            csr_wr;
   logic            adv;
   logic            own_over, par_over;

   logic               vld_ff [0:PROJ_LAT-1];
   logic [INDEX_W-1:0] idx_ff [0:PROJ_LAT-1];
   logic               hp_ff  [0:PROJ_LAT-1];

   logic               rsp_valid_ff, rsp_valid_in;
   logic [INDEX_W-1:0] rsp_index_ff;
   logic               rsp_sel_ff;

   assign reg_sel    = lccs_reg_type'(csr_paddr[4:2]);
   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         cam_ff                <= '0;
         scale_ff.pixel_scale  <= '0;
         scale_ff.error_budget <= BUDGET_W'(256);
      end else if (csr_wr) begin
         unique case (reg_sel)
            REG_CAMERA_X:     cam_ff.x <= csr_pwdata;
            REG_CAMERA_Y:     cam_ff.y <= csr_pwdata;
            REG_CAMERA_Z:     cam_ff.z <= csr_pwdata;
            REG_PIXEL_SCALE:  scale_ff.pixel_scale <= csr_pwdata;
            REG_ERROR_BUDGET: scale_ff.error_budget <= csr_pwdata[BUDGET_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (reg_sel)
         REG_CAMERA_X:     csr_prdata = cam_ff.x;
         REG_CAMERA_Y:     csr_prdata = cam_ff.y;
         REG_CAMERA_Z:     csr_prdata = cam_ff.z;
         REG_PIXEL_SCALE:  csr_prdata = scale_ff.pixel_scale;
         REG_ERROR_BUDGET: csr_prdata = CSR_DATA_W'(scale_ff.error_budget);
         default:          csr_prdata = '0;
      endcase
   end

   assign own_sph.err    = req_tdata[55:24];
   assign own_sph.cx     = req_tdata[87:56];
   assign own_sph.cy     = req_tdata[119:88];
   assign own_sph.cz     = req_tdata[151:120];
   assign own_sph.radius = req_tdata[183:152];
   assign par_sph.err    = req_tdata[215:184];
   assign par_sph.cx     = req_tdata[247:216];
   assign par_sph.cy     = req_tdata[279:248];
   assign par_sph.cz     = req_tdata[311:280];
   assign par_sph.radius = req_tdata[343:312];

   // The pipeline moves as one; it only holds while the output register is full.
   assign adv        = !rsp_valid_ff || rsp_tready;
   assign req_tready = adv;

   lccs_proj u_own (
      .clock (clock),
      .en    (adv),
      .cam   (cam_ff),
      .scale (scale_ff),
      .sph   (own_sph),
      .over  (own_over)
   );

   lccs_proj u_par (
      .clock (clock),
      .en    (adv),
      .cam   (cam_ff),
      .scale (scale_ff),
      .sph   (par_sph),
      .over  (par_over)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < PROJ_LAT; i++) begin
            vld_ff[i] <= 1'b0;
         end
      end else if (adv) begin
         vld_ff[0] <= req_tvalid;
         for (int i = 1; i < PROJ_LAT; i++) begin
            vld_ff[i] <= vld_ff[i-1];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         idx_ff[0] <= req_tdata[INDEX_W-1:0];
         hp_ff[0]  <= req_tuser[0];
         for (int i = 1; i < PROJ_LAT; i++) begin
            idx_ff[i] <= idx_ff[i-1];
            hp_ff[i]  <= hp_ff[i-1];
         end
      end
   end

   assign rsp_valid_in = adv ? vld_ff[PROJ_LAT-1] : rsp_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // A cluster without a parent sees its parent projection as infinite.
   always_ff @(posedge clock) begin
      if (adv) begin
         rsp_index_ff <= idx_ff[PROJ_LAT-1];
         rsp_sel_ff   <= !own_over && (!hp_ff[PROJ_LAT-1] || par_over);
      end
   end

   assign rsp_tvalid   = rsp_valid_ff;
   assign rsp_tdata    = rsp_index_ff;
   assign rsp_tuser[0] = rsp_sel_ff;

   `LCCS_ASSERT_SAME(a_ready_only_on_full_stall, clock, reset, !req_tready, rsp_valid_ff && !rsp_tready)
   `LCCS_ASSERT_NEXT(a_request_enters_pipe, clock, reset, req_tvalid && req_tready, vld_ff[0])
   `LCCS_ASSERT_NEXT(a_last_stage_reaches_output, clock, reset, vld_ff[PROJ_LAT-1] && adv, rsp_tvalid)

endmodule

`default_nettype wire

// ===== rtl/core/lccs_proj.sv =====
`default_nettype none

module lccs_proj
   import lccs_pkg::*;
(
   input  wire logic            clock,
   input  wire logic            en,
   input  wire lccs_cam_type    cam,
   input  wire lccs_scale_type  scale,
   input  wire lccs_sphere_type sph,
   output logic                 over
);

   logic signed [DIFF_W:0] dx_w, dy_w, dz_w;
   logic [DIFF_W:0]        nx_w, ny_w, nz_w;
   logic [DIFF_W-1:0]      ax_in, ay_in, az_in;

   logic [DIFF_W-1:0]  ax_ff, ay_ff, az_ff;
   logic [COORD_W-1:0] err_a_ff, rad_a_ff;
   logic [SQ_W-1:0]    sx_ff, sy_ff, sz_ff;
   logic [COORD_W-1:0] err_b_ff, rad_b_ff;

   logic [REM_W-1:0]   rem_ff  [0:ROOT_W];
   logic [ROOT_W-1:0]  root_ff [0:ROOT_W];
   logic [COORD_W-1:0] err_ff  [0:ROOT_W];
   logic [COORD_W-1:0] rad_ff  [0:ROOT_W];

   logic                 inside_d_ff, nz_d_ff;
   logic [ROOT_W-1:0]    denom_d_ff;
   logic [2*COORD_W-1:0] pa_d_ff;
   logic                 inside_e_ff, nz_e_ff;
   logic [2*COORD_W-1:0] pa_e_ff;
   logic [BUDGET_W+ROOT_W-1:0] pb_e_ff;
   logic                 over_ff;

   // The difference of two 32-bit signed values never reaches 2^32 in magnitude.
   assign dx_w  = {cam.x[COORD_W-1], cam.x} - {sph.cx[COORD_W-1], sph.cx};
   assign dy_w  = {cam.y[COORD_W-1], cam.y} - {sph.cy[COORD_W-1], sph.cy};
   assign dz_w  = {cam.z[COORD_W-1], cam.z} - {sph.cz[COORD_W-1], sph.cz};
   assign nx_w  = -dx_w;
   assign ny_w  = -dy_w;
   assign nz_w  = -dz_w;
   assign ax_in = dx_w[DIFF_W] ? nx_w[DIFF_W-1:0] : dx_w[DIFF_W-1:0];
   assign ay_in = dy_w[DIFF_W] ? ny_w[DIFF_W-1:0] : dy_w[DIFF_W-1:0];
   assign az_in = dz_w[DIFF_W] ? nz_w[DIFF_W-1:0] : dz_w[DIFF_W-1:0];

   always_ff @(posedge clock) begin
      if (en) begin
         ax_ff    <= ax_in;
         ay_ff    <= ay_in;
         az_ff    <= az_in;
         err_a_ff <= sph.err;
         rad_a_ff <= sph.radius;
         sx_ff    <= ax_ff * ax_ff;
         sy_ff    <= ay_ff * ay_ff;
         sz_ff    <= az_ff * az_ff;
         err_b_ff <= err_a_ff;
         rad_b_ff <= rad_a_ff;
         rem_ff[0]  <= REM_W'(sx_ff) + REM_W'(sy_ff) + REM_W'(sz_ff);
         root_ff[0] <= '0;
         err_ff[0]  <= err_b_ff;
         rad_ff[0]  <= rad_b_ff;
      end
   end

   // Restoring square root, one root bit per stage from the top down.
   for (genvar k = 0; k < ROOT_W; k++) begin : g_root
      localparam int B = ROOT_W - 1 - k;
      logic [REM_W-1:0] trial;

      assign trial = (REM_W'(root_ff[k]) << (B + 1)) | (REM_W'(1) << (2 * B));

      always_ff @(posedge clock) begin
         if (en) begin
            if (rem_ff[k] >= trial) begin
               rem_ff[k+1]  <= rem_ff[k] - trial;
               root_ff[k+1] <= root_ff[k] | (ROOT_W'(1) << B);
            end else begin
               rem_ff[k+1]  <= rem_ff[k];
               root_ff[k+1] <= root_ff[k];
            end
            err_ff[k+1] <= err_ff[k];
            rad_ff[k+1] <= rad_ff[k];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         inside_d_ff <= root_ff[ROOT_W] <= ROOT_W'(rad_ff[ROOT_W]);
         denom_d_ff  <= root_ff[ROOT_W] - ROOT_W'(rad_ff[ROOT_W]);
         nz_d_ff     <= err_ff[ROOT_W] != '0;
         pa_d_ff     <= err_ff[ROOT_W] * scale.pixel_scale;
         inside_e_ff <= inside_d_ff;
         nz_e_ff     <= nz_d_ff;
         pa_e_ff     <= pa_d_ff;
         pb_e_ff     <= scale.error_budget * denom_d_ff;
         over_ff     <= nz_e_ff && (inside_e_ff ||
                        (pa_e_ff > ((2*COORD_W)'(pb_e_ff) << BUDGET_SHIFT)));
      end
   end

   assign over = over_ff;

endmodule

`default_nettype wire
